// File: hdl/focl_pkg.sv
// Package for the FOC current loop: widths, register map, sine table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package focl_pkg;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int INV_SQRT3_Q15 = 18919;
    localparam int ADDR_W = 5;
    localparam logic [2:0] REG_POLE = 3'd0;
    localparam logic [2:0] REG_KPD = 3'd1;
    localparam logic [2:0] REG_KID = 3'd2;
    localparam logic [2:0] REG_KPQ = 3'd3;
    localparam logic [2:0] REG_KIQ = 3'd4;

    typedef struct packed {
        logic [15:0] phase_a_current;
        logic [15:0] phase_b_current;
        logic [15:0] mech_angle;
        logic [15:0] target_d;
        logic [15:0] target_q;
    } in_item_t;

    typedef struct packed {
        logic [15:0] elec_angle;
        logic [15:0] d_current;
        logic [15:0] q_current;
        logic [15:0] d_voltage;
        logic [15:0] q_voltage;
        logic [15:0] alpha_voltage;
        logic [15:0] beta_voltage;
    } out_item_t;

    typedef struct packed {
        logic [6:0]  pole_pairs;
        logic [15:0] kp_d;
        logic [15:0] ki_d;
        logic [15:0] kp_q;
        logic [15:0] ki_q;
    } cfg_t;

    // sine of a 16 bit phase in Q1.15, degree 9 odd polynomial per quarter
    function automatic logic signed [16:0] sin_q15(input logic [15:0] ph);
        logic [1:0]  q;
        logic [14:0] f;
        logic [63:0] x, x2, r;
        longint p;
        q = ph[15:14];
        f = {1'b0, ph[13:0]};
        if (q[0]) f = 15'h4000 - f;
        x = {33'd0, f, 16'd0};
        x2 = (x * x) >> 30;
        p = 172273;
        p = 5026995 - longint'((64'(p) * x2) >> 30);
        p = 85569306 - longint'((64'(p) * x2) >> 30);
        p = 693598668 - longint'((64'(p) * x2) >> 30);
        p = 1686629713 - longint'((64'(p) * x2) >> 30);
        r = (x * 64'(p)) >> 30;
        r = (r + 64'd16384) >> 15;
        if (r > 64'd32767) r = 64'd32767;
        sin_q15 = q[1] ? -$signed({1'b0, r[15:0]}) : $signed({1'b0, r[15:0]});
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
        if (v > 48'sd32767) sat16 = 16'sh7fff;
        else if (v < -48'sd32768) sat16 = 16'sh8000;
        else sat16 = v[15:0];
    endfunction
endpackage
`default_nettype wire

// File: hdl/focl_if.sv
// Valid/ready channel interface carrying one payload of type T.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface focl_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/foc_current_loop_core.sv
// FOC current loop top level: APB registers, front end, back-end sequencer.
// Depends on focl_pkg, focl_if, focl_front, focl_back.
//
// Usage: samples arrive as transfers on in_ch (valid/ready); results leave on
// out_ch. A one-entry queue between front and back holds the next sample while
// the back end works. The back end, through its single sequencer, handles one
// sample at a time (one state to take the sample, six compute states, one to
// offer the result) and takes no new sample until its result has been taken.
// A sample passes the queue register and then the sequencer states in order.
// If out_ch stalls the result is held and the back end stops; the queue then
// fills and in_ch ready drops. Reset clears PI state and sets register
// defaults (pole_pairs 1, kp 256, ki 0). Write registers only while idle.
`timescale 1ns / 1ps
`default_nettype none
module foc_current_loop_core #(
    parameter int SINE_TABLE_DEPTH = focl_pkg::SINE_TABLE_DEPTH,
    parameter int SAMPLE_BITS = focl_pkg::SAMPLE_BITS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [focl_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    focl_if.sink                             in_ch,
    focl_if.source                           out_ch
);
    focl_pkg::cfg_t cfg_reg;
    logic q_valid, q_ready;
    logic [95:0] q_data;
    logic [2:0] idx;
    assign idx = paddr[4:2];
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '{7'd1, 16'd256, 16'd0, 16'd256, 16'd0};
        else if (psel && penable && pwrite)
        begin
            priority case (idx)
                focl_pkg::REG_POLE: cfg_reg.pole_pairs <= pwdata[6:0];
                focl_pkg::REG_KPD:  cfg_reg.kp_d <= pwdata[15:0];
                focl_pkg::REG_KID:  cfg_reg.ki_d <= pwdata[15:0];
                focl_pkg::REG_KPQ:  cfg_reg.kp_q <= pwdata[15:0];
                focl_pkg::REG_KIQ:  cfg_reg.ki_q <= pwdata[15:0];
                default: ;
            endcase
        end
    end
    always_comb
    begin
        priority case (idx)
            focl_pkg::REG_POLE: prdata = {25'd0, cfg_reg.pole_pairs};
            focl_pkg::REG_KPD:  prdata = {16'd0, cfg_reg.kp_d};
            focl_pkg::REG_KID:  prdata = {16'd0, cfg_reg.ki_d};
            focl_pkg::REG_KPQ:  prdata = {16'd0, cfg_reg.kp_q};
            focl_pkg::REG_KIQ:  prdata = {16'd0, cfg_reg.ki_q};
            default: prdata = 32'd0;
        endcase
    end
    focl_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .pole_pairs(cfg_reg.pole_pairs),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );
    focl_back #(.DEPTH(SINE_TABLE_DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
    );
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
    a_q: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && !q_ready |=> q_valid) else $error("queue entry lost");
endmodule
`default_nettype wire

// File: hdl/focl_sine_rom.sv
// Sine table, one registered read per cycle.
// Depends on focl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module focl_sine_rom #(
    parameter int DEPTH = focl_pkg::SINE_TABLE_DEPTH
) (
    input  wire logic                     clk,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    output logic signed [16:0]            data_reg
);
    logic signed [16:0] rom [DEPTH];
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
            rom[i] = focl_pkg::sin_q15(16'((i * 65536) / DEPTH));
    end
    always_ff @(posedge clk)
    begin
        data_reg <= rom[addr];
    end
endmodule
`default_nettype wire

// File: hdl/focl_front.sv
// Front end: takes a transfer, samples currents, forms angle and Clarke terms.
// Depends on focl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module focl_front #(
    parameter int SAMPLE_BITS = focl_pkg::SAMPLE_BITS
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [6:0]        pole_pairs,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire focl_pkg::in_item_t in_data,
    output logic                   q_valid,
    input  wire logic              q_ready,
    output logic [95:0]            q_data
);
    localparam int DROP = (SAMPLE_BITS < 16) ? 16 - SAMPLE_BITS : 0;
    logic              full_reg;
    logic [95:0]       data_reg;
    logic signed [15:0] ia, ib;
    logic signed [17:0] s2;
    logic signed [33:0] bprod;
    logic signed [18:0] beta;
    logic [22:0]       ang;
    assign ia = $signed(in_data.phase_a_current & ~16'((1 << DROP) - 1));
    assign ib = $signed(in_data.phase_b_current & ~16'((1 << DROP) - 1));
    assign s2 = 18'(ia) + 18'(ib) * 18'sd2;
    assign bprod = 34'(s2) * 34'(focl_pkg::INV_SQRT3_Q15) + 34'sd16384;
    assign beta = bprod[33:15];
    assign ang = in_data.mech_angle * pole_pairs;
    assign in_ready = !full_reg || q_ready;
    assign q_valid = full_reg;
    assign q_data = data_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else if (in_ready)
            full_reg <= in_valid;
    end
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= {1'b0, ang[15:0], ia, beta, in_data.target_d, in_data.target_q,
                         12'd0};
    end
endmodule
`default_nettype wire

// File: hdl/focl_back.sv
// Back end sequencer: Park, PI and inverse Park, one step per state.
// Depends on focl_pkg and focl_sine_rom.
`timescale 1ns / 1ps
`default_nettype none
module focl_back #(
    parameter int DEPTH = focl_pkg::SINE_TABLE_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire focl_pkg::cfg_t cfg,
    input  wire logic          q_valid,
    output logic               q_ready,
    input  wire logic [95:0]   q_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output focl_pkg::out_item_t out_data
);
    localparam int AW = $clog2(DEPTH);
    localparam logic [3:0] S_IDLE = 4'd0, S_SIN = 4'd1, S_COS = 4'd2, S_PARK = 4'd3,
        S_PI = 4'd4, S_INV = 4'd5, S_OUT = 4'd6, S_WAIT = 4'd7;
    logic [3:0] st_reg;
    logic [15:0] ang_reg;
    logic signed [15:0] ia_reg, td_reg, tq_reg;
    logic signed [18:0] beta_reg;
    logic signed [16:0] s_reg, c_reg, rom_q;
    logic signed [15:0] id_reg, iq_reg, va_reg, vb_reg;
    logic signed [15:0] dacc_reg, qacc_reg;
    logic signed [16:0] dprev_reg, qprev_reg;
    logic [AW-1:0] addr;
    logic [AW-1:0] k;
    logic signed [47:0] t1, t2, t3, t4, sd, sq, ed, eq;
    assign k = ang_reg[15 -: AW];
    assign addr = (st_reg == S_SIN) ? k : AW'(k + AW'(DEPTH / 4));
    focl_sine_rom #(.DEPTH(DEPTH)) u_rom (.clk(clk), .addr(addr), .data_reg(rom_q));
    assign q_ready = (st_reg == S_IDLE);
    assign out_valid = (st_reg == S_WAIT);
    always_comb
    begin
        t1 = 48'(ia_reg) * 48'(c_reg) + 48'(beta_reg) * 48'(s_reg) + 48'sd16384;
        t2 = 48'(beta_reg) * 48'(c_reg) - 48'(ia_reg) * 48'(s_reg) + 48'sd16384;
        ed = 48'(td_reg) - 48'(id_reg);
        eq = 48'(tq_reg) - 48'(iq_reg);
        sd = 48'($signed({1'b0, cfg.kp_d})) * (ed - 48'(dprev_reg))
           + 48'($signed({1'b0, cfg.ki_d})) * ed + 48'sd128;
        sq = 48'($signed({1'b0, cfg.kp_q})) * (eq - 48'(qprev_reg))
           + 48'($signed({1'b0, cfg.ki_q})) * eq + 48'sd128;
        t3 = 48'(dacc_reg) * 48'(c_reg) - 48'(qacc_reg) * 48'(s_reg) + 48'sd16384;
        t4 = 48'(dacc_reg) * 48'(s_reg) + 48'(qacc_reg) * 48'(c_reg) + 48'sd16384;
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            dacc_reg <= '0; qacc_reg <= '0; dprev_reg <= '0; qprev_reg <= '0;
        end
        else
        begin
            unique case (st_reg)
                S_IDLE: if (q_valid) st_reg <= S_SIN;
                S_SIN:  st_reg <= S_COS;
                S_COS:  st_reg <= S_PARK;
                S_PARK: st_reg <= S_PI;
                S_PI:   st_reg <= S_INV;
                S_INV:
                begin
                    dacc_reg <= focl_pkg::sat16(48'(dacc_reg) + (sd >>> 8));
                    qacc_reg <= focl_pkg::sat16(48'(qacc_reg) + (sq >>> 8));
                    dprev_reg <= ed[16:0];
                    qprev_reg <= eq[16:0];
                    st_reg <= S_OUT;
                end
                S_OUT:  st_reg <= S_WAIT;
                S_WAIT: if (out_ready) st_reg <= S_IDLE;
                default: st_reg <= S_IDLE;
            endcase
        end
    end
    always_ff @(posedge clk)
    begin
        if (st_reg == S_IDLE && q_valid)
        begin
            ang_reg <= q_data[94:79];
            ia_reg <= q_data[78:63];
            beta_reg <= q_data[62:44];
            td_reg <= q_data[43:28];
            tq_reg <= q_data[27:12];
        end
        if (st_reg == S_COS) s_reg <= rom_q;
        if (st_reg == S_PARK)
        begin
            c_reg <= rom_q;
        end
        if (st_reg == S_PI)
        begin
            id_reg <= focl_pkg::sat16(t1 >>> 15);
            iq_reg <= focl_pkg::sat16(t2 >>> 15);
        end
        if (st_reg == S_OUT)
        begin
            va_reg <= focl_pkg::sat16(t3 >>> 15);
            vb_reg <= focl_pkg::sat16(t4 >>> 15);
        end
    end
    assign out_data = '{ang_reg, id_reg, iq_reg, dacc_reg, qacc_reg, va_reg, vb_reg};
endmodule
`default_nettype wire

// File: test/tb_foc_current_loop_core.sv
// Testbench for foc_current_loop_core: directed and random samples, PI state tracking,
// APB register writes between phases. Depends on focl_pkg, focl_if and the core RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb_foc_current_loop_core;
    localparam int LATENCY = 12;
    localparam int WATCHDOG_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [focl_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    focl_if #(.T(focl_pkg::in_item_t)) sample_ch ();
    focl_if #(.T(focl_pkg::out_item_t)) result_ch ();

    foc_current_loop_core i_dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_ch(sample_ch.sink), .out_ch(result_ch.source)
    );

    always #4 clk = ~clk;

    // model state
    logic [6:0] m_pole;
    logic [15:0] m_kpd, m_kid, m_kpq, m_kiq;
    longint m_acc_d, m_acc_q, m_prev_d, m_prev_q;
    focl_pkg::out_item_t expected_q[$];

    int errors = 0;
    int idle_pct = 29;
    bit hold_rx = 1'b0;
    int idle_cycles = 0;

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint sine_of(logic [15:0] ph);
        logic [1:0] quad;
        longint unsigned frac, x, x2, r;
        longint poly;
        quad = ph[15:14];
        frac = ph[13:0];
        if (quad[0]) frac = 64'h4000 - frac;
        x = frac << 16;
        x2 = (x * x) >> 30;
        poly = 172273;
        poly = 5026995 - longint'((longint'(poly) * x2) >> 30);
        poly = 85569306 - longint'((longint'(poly) * x2) >> 30);
        poly = 693598668 - longint'((longint'(poly) * x2) >> 30);
        poly = 1686629713 - longint'((longint'(poly) * x2) >> 30);
        r = (x * longint'(poly)) >> 30;
        r = (r + 16384) >> 15;
        if (r > 32767) r = 32767;
        return quad[1] ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint keep_bits(logic [15:0] raw);
        logic [15:0] v;
        v = raw;
        if (focl_pkg::SAMPLE_BITS < 16)
            v = v & ~((16'd1 << (16 - focl_pkg::SAMPLE_BITS)) - 16'd1);
        return longint'($signed(v));
    endfunction

    task automatic pi_update(input longint target, input longint meas, input logic [15:0] kp,
                             input logic [15:0] ki, inout longint acc, inout longint prev);
        longint err, stepv;
        err = target - meas;
        stepv = longint'(kp) * (err - prev) + longint'(ki) * err;
        acc = clamp16(acc + round_shift(stepv, 8));
        prev = err;
    endtask

    task automatic predict_loop(input focl_pkg::in_item_t s);
        focl_pkg::out_item_t r;
        logic [15:0] ang, ph;
        longint ia, ib, sn, cs, beta, id, iq;
        ia = keep_bits(s.phase_a_current);
        ib = keep_bits(s.phase_b_current);
        ang = 16'(s.mech_angle * m_pole);
        ph = 16'(((longint'(ang) * focl_pkg::SINE_TABLE_DEPTH) >> 16) * 65536
                 / focl_pkg::SINE_TABLE_DEPTH);
        sn = sine_of(ph);
        cs = sine_of(ph + 16'h4000);
        beta = round_shift((ia + 2 * ib) * focl_pkg::INV_SQRT3_Q15, 15);
        id = clamp16(round_shift(ia * cs + beta * sn, 15));
        iq = clamp16(round_shift(beta * cs - ia * sn, 15));
        pi_update(longint'($signed(s.target_d)), id, m_kpd, m_kid, m_acc_d, m_prev_d);
        pi_update(longint'($signed(s.target_q)), iq, m_kpq, m_kiq, m_acc_q, m_prev_q);
        r.elec_angle = ang;
        r.d_current = 16'(id);
        r.q_current = 16'(iq);
        r.d_voltage = 16'(m_acc_d);
        r.q_voltage = 16'(m_acc_q);
        r.alpha_voltage = 16'(clamp16(round_shift(m_acc_d * cs - m_acc_q * sn, 15)));
        r.beta_voltage = 16'(clamp16(round_shift(m_acc_d * sn + m_acc_q * cs, 15)));
        expected_q.push_back(r);
    endtask

    // leaves psel high; set_gains closes the sequence of writes
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= focl_pkg::ADDR_W'(idx) << 2;
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            focl_pkg::REG_POLE: m_pole = val[6:0];
            focl_pkg::REG_KPD: m_kpd = val[15:0];
            focl_pkg::REG_KID: m_kid = val[15:0];
            focl_pkg::REG_KPQ: m_kpq = val[15:0];
            focl_pkg::REG_KIQ: m_kiq = val[15:0];
            default: ;
        endcase
    endtask

    task automatic drain_results();
        sample_ch.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic set_gains(input logic [6:0] pp, input logic [15:0] kpd, input logic [15:0] kid,
                             input logic [15:0] kpq, input logic [15:0] kiq);
        drain_results();
        reg_write(focl_pkg::REG_POLE, 32'(pp));
        reg_write(focl_pkg::REG_KPD, 32'(kpd));
        reg_write(focl_pkg::REG_KID, 32'(kid));
        reg_write(focl_pkg::REG_KPQ, 32'(kpq));
        reg_write(focl_pkg::REG_KIQ, 32'(kiq));
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // sample_ch.valid stays high on return; drain_results drops it
    task automatic send_sample(input focl_pkg::in_item_t s);
        while ($urandom_range(99) < idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.data <= s;
        @(posedge clk);
        while (!sample_ch.ready) @(posedge clk);
        predict_loop(s);
    endtask

    function automatic focl_pkg::in_item_t rand_sample();
        focl_pkg::in_item_t s;
        s.phase_a_current = 16'($urandom);
        s.phase_b_current = 16'($urandom);
        s.mech_angle = 16'($urandom);
        s.target_d = 16'($urandom);
        s.target_q = 16'($urandom);
        if ($urandom_range(3) == 0)
        begin
            s.phase_a_current = 16'($signed(16'($urandom)) >>> 6);
            s.phase_b_current = 16'($signed(16'($urandom)) >>> 6);
        end
        return s;
    endfunction

    task automatic test_directed();
        logic [15:0] vals[6] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001, 16'h4000};
        focl_pkg::in_item_t s;
        for (int i = 0; i < 18; i++)
        begin
            s.phase_a_current = vals[i % 6];
            s.phase_b_current = vals[(i + 1) % 6];
            s.mech_angle = (i < 6) ? vals[i] : 16'(i * 16'h1555);
            s.target_d = vals[(i + 2) % 6];
            s.target_q = vals[(i + 3) % 6];
            send_sample(s);
        end
    endtask

    task automatic test_pole_pairs();
        logic [6:0] pp[4] = '{7'd0, 7'd64, 7'd127, 7'd7};
        foreach (pp[j])
        begin
            set_gains(pp[j], 16'd256, 16'd0, 16'd256, 16'd0);
            for (int i = 0; i < 6; i++) send_sample(rand_sample());
        end
    endtask

    task automatic test_random_gains(input int count, input int phases);
        for (int p = 0; p < phases; p++)
        begin
            case (p % 4)
                0: set_gains(7'($urandom_range(1, 64)), 16'($urandom_range(0, 1024)),
                             16'($urandom_range(0, 64)), 16'($urandom_range(0, 1024)),
                             16'($urandom_range(0, 64)));
                1: set_gains(7'($urandom), 16'hffff, 16'hffff, 16'hffff, 16'hffff);
                2: set_gains(7'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom), 16'($urandom));
                default: set_gains(7'd4, 16'd0, 16'd0, 16'd0, 16'd0);
            endcase
            for (int i = 0; i < count; i++) send_sample(rand_sample());
        end
    endtask

    task automatic test_no_idle();
        idle_pct = 0;
        set_gains(7'd3, 16'd300, 16'd20, 16'd300, 16'd20);
        for (int i = 0; i < 150; i++) send_sample(rand_sample());
        idle_pct = 29;
    endtask

    task automatic test_back_pressure();
        hold_rx = 1'b1;
        for (int i = 0; i < 20; i++) send_sample(rand_sample());
        drain_results();
    endtask

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else if (hold_rx)
            result_ch.ready <= 1'b0;
        else
            result_ch.ready <= ($urandom_range(99) >= idle_pct);
    end

    // long hold-off of the receiver, counted here
    initial
    begin
        int held;
        wait (hold_rx);
        held = 0;
        while (held < 300)
        begin
            @(posedge clk);
            held++;
        end
        hold_rx = 1'b0;
    end

    // result checker
    always @(posedge clk)
    begin
        focl_pkg::out_item_t got, exp_r;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = result_ch.data;
            if (expected_q.size() == 0)
            begin
                $error("unexpected transfer on result channel");
                errors++;
            end
            else
            begin
                exp_r = expected_q.pop_front();
                if (got.elec_angle !== exp_r.elec_angle)
                begin
                    $error("elec_angle exp %0d got %0d", exp_r.elec_angle, got.elec_angle);
                    errors++;
                end
                if (got.d_current !== exp_r.d_current)
                begin
                    $error("d_current exp %0d got %0d", $signed(exp_r.d_current),
                           $signed(got.d_current));
                    errors++;
                end
                if (got.q_current !== exp_r.q_current)
                begin
                    $error("q_current exp %0d got %0d", $signed(exp_r.q_current),
                           $signed(got.q_current));
                    errors++;
                end
                if (got.d_voltage !== exp_r.d_voltage)
                begin
                    $error("d_voltage exp %0d got %0d", $signed(exp_r.d_voltage),
                           $signed(got.d_voltage));
                    errors++;
                end
                if (got.q_voltage !== exp_r.q_voltage)
                begin
                    $error("q_voltage exp %0d got %0d", $signed(exp_r.q_voltage),
                           $signed(got.q_voltage));
                    errors++;
                end
                if (got.alpha_voltage !== exp_r.alpha_voltage)
                begin
                    $error("alpha_voltage exp %0d got %0d", $signed(exp_r.alpha_voltage),
                           $signed(got.alpha_voltage));
                    errors++;
                end
                if (got.beta_voltage !== exp_r.beta_voltage)
                begin
                    $error("beta_voltage exp %0d got %0d", $signed(exp_r.beta_voltage),
                           $signed(got.beta_voltage));
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_foc_current_loop_core: done, errors");
            $finish;
        end
    end

    initial
    begin
        sample_ch.valid = 1'b0;
        sample_ch.data = '0;
        m_pole = 7'd1;
        m_kpd = 16'd256;
        m_kid = 16'd0;
        m_kpq = 16'd256;
        m_kiq = 16'd0;
        m_acc_d = 0;
        m_acc_q = 0;
        m_prev_d = 0;
        m_prev_q = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_pole_pairs();
        test_back_pressure();
        test_no_idle();
        test_random_gains(110, 12);
        drain_results();
        if (errors == 0)
            $display("tb_foc_current_loop_core: done, clean");
        else
            $display("tb_foc_current_loop_core: done, errors");
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
hdl/focl_pkg.sv
hdl/focl_if.sv
hdl/focl_sine_rom.sv
hdl/focl_front.sv
hdl/focl_back.sv
hdl/foc_current_loop_core.sv
test/tb_foc_current_loop_core.sv
